>>> hdl/assert_macros.svh
// assertion macros included by the evaluator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_IMPLY(name, clk, rst, ante, cons, msg)

`define ASSERT_NEXT(name, clk, rst, ante, cons, msg)

`endif

`endif

>>> hdl/cbpe_pkg.sv
// constants and types for the cubic bezier point evaluator
package cbpe_pkg;

  localparam int DEF_COORD_WIDTH     = 16;
  localparam int DEF_PARAM_FRAC_BITS = 15;
  localparam int NUM_POINTS          = 4;
  localparam int NUM_LANES           = 3;
  localparam int CFG_INDEX_WIDTH     = 4;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_START_POINT   = 4'd0,
    REG_FIRST_HANDLE  = 4'd1,
    REG_SECOND_HANDLE = 4'd2,
    REG_END_POINT     = 4'd3
  } cfg_reg_t;

endpackage

>>> hdl/cubic_bezier_point_evaluator.sv
// cubic bezier point evaluator: pipelined weight and weighted-sum datapath
//
//  channel   dir  handshake            payload
//  cfg       in   cfg_valid/cfg_ready  cfg_index, cfg_data
//  in        in   in_valid/in_ready    curve_param
//  out       out  out_valid/out_ready  point_x, point_y, point_z
//
// seven register stages, one transaction per cycle while the output is not stalled
// stage depth is set by the 16x17 and 15x17 weight multipliers and the 17x16 point multipliers
// reset clears the stage valid bits and the four control points
// a stall holds each occupied stage; empty stages keep filling, cfg_ready is always high
`include "assert_macros.svh"

module cubic_bezier_point_evaluator
  import cbpe_pkg::*;
#(
  parameter int COORD_WIDTH     = DEF_COORD_WIDTH,
  parameter int PARAM_FRAC_BITS = DEF_PARAM_FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  logic [3*COORD_WIDTH-1:0]     cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [PARAM_FRAC_BITS:0]     curve_param,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_WIDTH-1:0] point_x,
  output logic signed [COORD_WIDTH-1:0] point_y,
  output logic signed [COORD_WIDTH-1:0] point_z
);

  localparam int F      = PARAM_FRAC_BITS;
  localparam int C      = COORD_WIDTH;
  localparam int NSTAGE = 7;
  localparam int TW     = F + 1;
  localparam int SQW    = 2 * F + 1;
  localparam int MW     = F + 2;
  localparam int HIW    = F + 1;
  localparam int HPW    = HIW + MW;
  localparam int LPW    = F + MW;
  localparam int SW     = 3 * F + 3;
  localparam int PW     = F + C + 2;
  localparam int TOTW   = PW + 2;
  localparam int QW     = TOTW - F;

  localparam logic [TW-1:0] PARAM_ONE = {1'b1, {F{1'b0}}};
  localparam logic [SW-1:0] RND_W = {{(F + 3){1'b0}}, 1'b1, {(2 * F - 1){1'b0}}};
  localparam logic [TOTW-1:0] RND_S = {{(TOTW - F){1'b0}}, 1'b1, {(F - 1){1'b0}}};
  localparam logic signed [QW-1:0] QMAX = {{(QW - C + 1){1'b0}}, {(C - 1){1'b1}}};
  localparam logic signed [QW-1:0] QMIN = ~QMAX;
  localparam logic [C-1:0] SAT_HI = {1'b0, {(C - 1){1'b1}}};
  localparam logic [C-1:0] SAT_LO = {1'b1, {(C - 1){1'b0}}};
  localparam logic [TW+1:0] WSUM_TOL = (TW + 2)'(2);

  // control points
  logic [3*C-1:0] pts [NUM_POINTS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_POINTS; i++) begin
        pts[i] <= '0;
      end
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_START_POINT:   pts[0] <= cfg_data;
        REG_FIRST_HANDLE:  pts[1] <= cfg_data;
        REG_SECOND_HANDLE: pts[2] <= cfg_data;
        REG_END_POINT:     pts[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage flow control
  logic [NSTAGE-1:0] vld;
  logic [NSTAGE-1:0] load;

  always_comb begin
    load[NSTAGE-1] = !vld[NSTAGE-1] || out_ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      load[k] = !vld[k] || load[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NSTAGE; k++) begin
        if (load[k]) begin
          vld[k] <= (k == 0) ? in_valid : vld[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  assign in_ready  = load[0];
  assign out_valid = vld[NSTAGE-1];

  // stage 1: clamp t, form u
  logic [TW-1:0] t1, u1;
  logic [TW-1:0] t_sat;

  assign t_sat = (curve_param > PARAM_ONE) ? PARAM_ONE : curve_param;

  always_ff @(posedge clk) begin
    if (load[0]) begin
      t1 <= t_sat;
      u1 <= PARAM_ONE - t_sat;
    end
  end

  // stage 2: squares and tripled factors
  logic [SQW-1:0] tt2, uu2;
  logic [MW-1:0]  t2, u2, t3x2, u3x2;

  always_ff @(posedge clk) begin
    if (load[1]) begin
      tt2  <= SQW'(t1) * SQW'(t1);
      uu2  <= SQW'(u1) * SQW'(u1);
      t2   <= {1'b0, t1};
      u2   <= {1'b0, u1};
      t3x2 <= {1'b0, t1} + {t1, 1'b0};
      u3x2 <= {1'b0, u1} + {u1, 1'b0};
    end
  end

  // stage 3: cube partial products, square split into high and low halves
  logic [SQW-1:0] sq_op [NUM_POINTS];
  logic [MW-1:0]  m_op  [NUM_POINTS];
  logic [HPW-1:0] hi_p  [NUM_POINTS];
  logic [LPW-1:0] lo_p  [NUM_POINTS];

  always_comb begin
    sq_op[0] = uu2;
    m_op[0]  = u2;
    sq_op[1] = uu2;
    m_op[1]  = t3x2;
    sq_op[2] = tt2;
    m_op[2]  = u3x2;
    sq_op[3] = tt2;
    m_op[3]  = t2;
  end

  always_ff @(posedge clk) begin
    if (load[2]) begin
      for (int i = 0; i < NUM_POINTS; i++) begin
        hi_p[i] <= HPW'(sq_op[i][SQW-1:F]) * HPW'(m_op[i]);
        lo_p[i] <= LPW'(sq_op[i][F-1:0]) * LPW'(m_op[i]);
      end
    end
  end

  // stage 4: rounded weights
  logic [SW-1:0] wfull [NUM_POINTS];
  logic [TW-1:0] wgt   [NUM_POINTS];

  always_comb begin
    for (int i = 0; i < NUM_POINTS; i++) begin
      wfull[i] = {hi_p[i], {F{1'b0}}} + {{(SW - LPW){1'b0}}, lo_p[i]} + RND_W;
    end
  end

  always_ff @(posedge clk) begin
    if (load[3]) begin
      for (int i = 0; i < NUM_POINTS; i++) begin
        wgt[i] <= wfull[i][2*F +: TW];
      end
    end
  end

  // stage 5: weighted coordinates
  logic signed [PW-1:0] prod [NUM_POINTS][NUM_LANES];

  always_ff @(posedge clk) begin
    if (load[4]) begin
      for (int i = 0; i < NUM_POINTS; i++) begin
        for (int l = 0; l < NUM_LANES; l++) begin
          prod[i][l] <= PW'($signed({1'b0, wgt[i]})) * PW'($signed(pts[i][l*C +: C]));
        end
      end
    end
  end

  // stage 6: pair sums
  logic signed [PW:0] pair [2][NUM_LANES];

  always_ff @(posedge clk) begin
    if (load[5]) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        pair[0][l] <= $signed({prod[0][l][PW-1], prod[0][l]})
                    + $signed({prod[1][l][PW-1], prod[1][l]});
        pair[1][l] <= $signed({prod[2][l][PW-1], prod[2][l]})
                    + $signed({prod[3][l][PW-1], prod[3][l]});
      end
    end
  end

  // stage 7: round, saturate, output register
  logic [TOTW-1:0]        total [NUM_LANES];
  logic signed [QW-1:0]   q     [NUM_LANES];
  logic [C-1:0]           sat   [NUM_LANES];
  logic [C-1:0]           pq    [NUM_LANES];

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      total[l] = {pair[0][l][PW], pair[0][l]} + {pair[1][l][PW], pair[1][l]} + RND_S;
      q[l]     = $signed(total[l][TOTW-1:F]);
      if (q[l] > QMAX) begin
        sat[l] = SAT_HI;
      end else if (q[l] < QMIN) begin
        sat[l] = SAT_LO;
      end else begin
        sat[l] = q[l][C-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load[6]) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        pq[l] <= sat[l];
      end
    end
  end

  assign point_x = $signed(pq[0]);
  assign point_y = $signed(pq[1]);
  assign point_z = $signed(pq[2]);

  // weight sum stays within rounding distance of one
  logic [TW+1:0] wsum;

  assign wsum = {2'b00, wgt[0]} + {2'b00, wgt[1]} + {2'b00, wgt[2]} + {2'b00, wgt[3]};

  `ASSERT_IMPLY(a_full_when_blocked, clk, rst, !in_ready, &vld, "input blocked with a free stage")
  `ASSERT_IMPLY(a_param_clamped, clk, rst, vld[0], t1 <= PARAM_ONE, "clamped parameter above one")
  `ASSERT_IMPLY(a_weight_sum, clk, rst, vld[4], (wsum + WSUM_TOL >= {2'b00, PARAM_ONE}) && (wsum <= {2'b00, PARAM_ONE} + WSUM_TOL), "weights do not sum to one")

endmodule
